FILE: hdl/desrf_pkg.sv
// Package with the DES round function tables and the per-stage helper functions.
package desrf_pkg;

    localparam int HALF_W = 32;
    localparam int KEY_W  = 48;
    localparam int NUM_SBOX = 8;

    // Expansion table, entries number the source bits MSB-first from 1.
    localparam logic [5:0] E_TAB [KEY_W] = '{
        6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,
        6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
        6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13,
        6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21,
        6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
        6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29,
        6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
    };

    // Output permutation, same numbering.
    localparam logic [5:0] P_TAB [HALF_W] = '{
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // S-boxes, indexed by row * 16 + column.
    localparam logic [3:0] SBOX [NUM_SBOX][64] = '{
        '{ 4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
           4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7,
           4'd0,  4'd15, 4'd7,  4'd4,  4'd14, 4'd2,  4'd13, 4'd1,
           4'd10, 4'd6,  4'd12, 4'd11, 4'd9,  4'd5,  4'd3,  4'd8,
           4'd4,  4'd1,  4'd14, 4'd8,  4'd13, 4'd6,  4'd2,  4'd11,
           4'd15, 4'd12, 4'd9,  4'd7,  4'd3,  4'd10, 4'd5,  4'd0,
           4'd15, 4'd12, 4'd8,  4'd2,  4'd4,  4'd9,  4'd1,  4'd7,
           4'd5,  4'd11, 4'd3,  4'd14, 4'd10, 4'd0,  4'd6,  4'd13 },
        '{ 4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
           4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10,
           4'd3,  4'd13, 4'd4,  4'd7,  4'd15, 4'd2,  4'd8,  4'd14,
           4'd12, 4'd0,  4'd1,  4'd10, 4'd6,  4'd9,  4'd11, 4'd5,
           4'd0,  4'd14, 4'd7,  4'd11, 4'd10, 4'd4,  4'd13, 4'd1,
           4'd5,  4'd8,  4'd12, 4'd6,  4'd9,  4'd3,  4'd2,  4'd15,
           4'd13, 4'd8,  4'd10, 4'd1,  4'd3,  4'd15, 4'd4,  4'd2,
           4'd11, 4'd6,  4'd7,  4'd12, 4'd0,  4'd5,  4'd14, 4'd9 },
        '{ 4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
           4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8,
           4'd13, 4'd7,  4'd0,  4'd9,  4'd3,  4'd4,  4'd6,  4'd10,
           4'd2,  4'd8,  4'd5,  4'd14, 4'd12, 4'd11, 4'd15, 4'd1,
           4'd13, 4'd6,  4'd4,  4'd9,  4'd8,  4'd15, 4'd3,  4'd0,
           4'd11, 4'd1,  4'd2,  4'd12, 4'd5,  4'd10, 4'd14, 4'd7,
           4'd1,  4'd10, 4'd13, 4'd0,  4'd6,  4'd9,  4'd8,  4'd7,
           4'd4,  4'd15, 4'd14, 4'd3,  4'd11, 4'd5,  4'd2,  4'd12 },
        '{ 4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
           4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15,
           4'd13, 4'd8,  4'd11, 4'd5,  4'd6,  4'd15, 4'd0,  4'd3,
           4'd4,  4'd7,  4'd2,  4'd12, 4'd1,  4'd10, 4'd14, 4'd9,
           4'd10, 4'd6,  4'd9,  4'd0,  4'd12, 4'd11, 4'd7,  4'd13,
           4'd15, 4'd1,  4'd3,  4'd14, 4'd5,  4'd2,  4'd8,  4'd4,
           4'd3,  4'd15, 4'd0,  4'd6,  4'd10, 4'd1,  4'd13, 4'd8,
           4'd9,  4'd4,  4'd5,  4'd11, 4'd12, 4'd7,  4'd2,  4'd14 },
        '{ 4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
           4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9,
           4'd14, 4'd11, 4'd2,  4'd12, 4'd4,  4'd7,  4'd13, 4'd1,
           4'd5,  4'd0,  4'd15, 4'd10, 4'd3,  4'd9,  4'd8,  4'd6,
           4'd4,  4'd2,  4'd1,  4'd11, 4'd10, 4'd13, 4'd7,  4'd8,
           4'd15, 4'd9,  4'd12, 4'd5,  4'd6,  4'd3,  4'd0,  4'd14,
           4'd11, 4'd8,  4'd12, 4'd7,  4'd1,  4'd14, 4'd2,  4'd13,
           4'd6,  4'd15, 4'd0,  4'd9,  4'd10, 4'd4,  4'd5,  4'd3 },
        '{ 4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
           4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11,
           4'd10, 4'd15, 4'd4,  4'd2,  4'd7,  4'd12, 4'd9,  4'd5,
           4'd6,  4'd1,  4'd13, 4'd14, 4'd0,  4'd11, 4'd3,  4'd8,
           4'd9,  4'd14, 4'd15, 4'd5,  4'd2,  4'd8,  4'd12, 4'd3,
           4'd7,  4'd0,  4'd4,  4'd10, 4'd1,  4'd13, 4'd11, 4'd6,
           4'd4,  4'd3,  4'd2,  4'd12, 4'd9,  4'd5,  4'd15, 4'd10,
           4'd11, 4'd14, 4'd1,  4'd7,  4'd6,  4'd0,  4'd8,  4'd13 },
        '{ 4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
           4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1,
           4'd13, 4'd0,  4'd11, 4'd7,  4'd4,  4'd9,  4'd1,  4'd10,
           4'd14, 4'd3,  4'd5,  4'd12, 4'd2,  4'd15, 4'd8,  4'd6,
           4'd1,  4'd4,  4'd11, 4'd13, 4'd12, 4'd3,  4'd7,  4'd14,
           4'd10, 4'd15, 4'd6,  4'd8,  4'd0,  4'd5,  4'd9,  4'd2,
           4'd6,  4'd11, 4'd13, 4'd8,  4'd1,  4'd4,  4'd10, 4'd7,
           4'd9,  4'd5,  4'd0,  4'd15, 4'd14, 4'd2,  4'd3,  4'd12 },
        '{ 4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
           4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7,
           4'd1,  4'd15, 4'd13, 4'd8,  4'd10, 4'd3,  4'd7,  4'd4,
           4'd12, 4'd5,  4'd6,  4'd11, 4'd0,  4'd14, 4'd9,  4'd2,
           4'd7,  4'd11, 4'd4,  4'd1,  4'd9,  4'd12, 4'd14, 4'd2,
           4'd0,  4'd6,  4'd10, 4'd13, 4'd15, 4'd3,  4'd5,  4'd8,
           4'd2,  4'd1,  4'd14, 4'd7,  4'd4,  4'd10, 4'd8,  4'd13,
           4'd15, 4'd12, 4'd9,  4'd0,  4'd3,  4'd5,  4'd6,  4'd11 }
    };

    // Expands the right half to 48 bits; every output bit is a plain wire.
    function automatic logic [KEY_W-1:0] f_expand(input logic [HALF_W-1:0] half);
        logic [KEY_W-1:0] e;
        e = '0;
        for (int k = 0; k < KEY_W; k++) begin
            e[KEY_W-1-k] = half[5'(HALF_W - int'(E_TAB[k]))];
        end
        return e;
    endfunction

    // Runs the eight 6-bit groups through their S-boxes in parallel.
    function automatic logic [HALF_W-1:0] f_substitute(input logic [KEY_W-1:0] x);
        logic [HALF_W-1:0] joined;
        logic [5:0]        grp;
        joined = '0;
        for (int k = 0; k < NUM_SBOX; k++) begin
            grp = x[KEY_W-1-6*k -: 6];
            joined[HALF_W-1-4*k -: 4] = SBOX[k][{grp[5], grp[0], grp[4:1]}];
        end
        return joined;
    endfunction

    // Applies the P permutation.
    function automatic logic [HALF_W-1:0] f_permute(input logic [HALF_W-1:0] joined);
        logic [HALF_W-1:0] res;
        res = '0;
        for (int k = 0; k < HALF_W; k++) begin
            res[HALF_W-1-k] = joined[5'(HALF_W - int'(P_TAB[k]))];
        end
        return res;
    endfunction

endpackage

FILE: hdl/des_round_function_unit.sv
// Three-stage pipelined DES round function (expansion, S-boxes, permutation).
//
// This unit computes the DES Feistel function f(R, K) for one request per clock while o_stall is low.
// Each request carries a 32-bit right half and a 48-bit round subkey, both numbered
// MSB-first as in the published cipher definition, and yields one 32-bit result.
// The work runs through three register stages: the first expands the half with the
// E table and XORs in the subkey, the second looks up the eight S-boxes, and the
// third applies the P permutation into the output register. An accepted request passes
// through r_x1, r_s2 and r_p3 to o_valid, and when the output side does not stall a new
// request is taken every cycle. When the output stalls, the pipeline closes up its empty
// stages and only raises o_stall once all three stages hold a request. There is no
// configuration and no state beyond the pipeline itself, so reset only clears the
// valid bits.
module des_round_function_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [desrf_pkg::HALF_W-1:0]  i_right_half,
    input  logic [desrf_pkg::KEY_W-1:0]   i_round_subkey,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [desrf_pkg::HALF_W-1:0]  o_round_output
);
    import desrf_pkg::*;

    // Stage registers and their valid bits.
    logic              r_v1, r_v2, r_v3;
    logic [KEY_W-1:0]  r_x1;
    logic [HALF_W-1:0] r_s2;
    logic [HALF_W-1:0] r_p3;

    // Next values of the stage payloads.
    logic [KEY_W-1:0]  n_x1;
    logic [HALF_W-1:0] n_s2;
    logic [HALF_W-1:0] n_p3;

    // A stage may load when it is empty or its contents move on this cycle.
    logic adv1, adv2, adv3;

    assign adv3 = !r_v3 || !i_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_stall = !adv1;

    assign n_x1 = f_expand(i_right_half) ^ i_round_subkey;
    assign n_s2 = f_substitute(r_x1);
    assign n_p3 = f_permute(r_s2);

    // Valid bits are control state and take the reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers load only with a valid request, which keeps a stalled
    // result stable at the output.
    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_x1 <= n_x1;
        end
        if (adv2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (adv3 && r_v2) begin
            r_p3 <= n_p3;
        end
    end

    assign o_valid        = r_v3;
    assign o_round_output = r_p3;

endmodule

FILE: hdl/desrf_checker.sv
// Port-level checker for the DES round function unit and its bind statement.
module desrf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [desrf_pkg::HALF_W-1:0]  o_round_output
);

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A stalled result stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_round_output))
        else $error("stalled result changed or vanished");

    // Without an output stall the input is never stalled.
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output is free");

    // An accepted request reaches the output when no output stall comes while it passes the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_stall) ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("request did not arrive after three free cycles");

    // With no new request and no output stall, the pipeline drains.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!in_acc && !i_stall) ##1 (!in_acc && !i_stall) ##1 (!in_acc && !i_stall)
        |=> !o_valid)
        else $error("result appeared with no request behind it");

endmodule

bind des_round_function_unit desrf_checker u_desrf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_round_output (o_round_output)
);
